// ===== hw/rtl/dirty_block_writeback_coalescer_defines.svh =====
// Assertion macros shared by the checkers of the dirty block coalescer.
// They expect clk and rst_n in the enclosing scope.
`ifndef DIRTY_BLOCK_WRITEBACK_COALESCER_DEFINES_SVH
`define DIRTY_BLOCK_WRITEBACK_COALESCER_DEFINES_SVH

// pre at one edge implies post at the next edge
`define DBWC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dbwc: next-cycle check failed");

// pre implies post at the same edge
`define DBWC_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dbwc: same-cycle check failed");

`endif

// ===== hw/rtl/dbwc_pkg.sv =====
package dbwc_pkg;

    localparam int unsigned HEAD_COUNT_DEF     = 8;
    localparam int unsigned TRACK_SIZE_DEF     = 10240;
    localparam int unsigned CYLINDER_COUNT_DEF = 1024;

    localparam int unsigned BLK_BYTES = 512;
    localparam int unsigned BLK_SHIFT = 9;

    // runs reported per flush; extra runs fold into the last one
    localparam int unsigned MAX_RUNS   = 4;
    localparam int unsigned RUN_SLOT_W = $clog2(MAX_RUNS);
    localparam int unsigned RUN_CNT_W  = $clog2(MAX_RUNS + 1);

    localparam int unsigned ADDR_W = 27;
    localparam int unsigned LEN_W  = 17;

    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_OVERFLOW = 2'd1;
    localparam logic [1:0] REQ_FLUSH    = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] head;
        logic [9:0] cylinder;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] storage_addr;
        logic [LEN_W-1:0]  run_length;
        logic              last_run;
    } rsp_t;

    // scan stream into the run collector
    typedef struct packed {
        logic start;
        logic step;
        logic dirty;
        logic finish;
    } scan_ctl_t;

endpackage

// ===== hw/rtl/dbwc_ram.sv =====
module dbwc_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/dbwc_runs.sv =====
module dbwc_runs
    import dbwc_pkg::*;
#(
    parameter int unsigned IDX_W = 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  scan_ctl_t             ctl,
    input  logic [IDX_W-1:0]      idx,
    input  logic [RUN_SLOT_W-1:0] rd_sel,
    output logic [RUN_CNT_W-1:0]  run_count,
    output logic [IDX_W-1:0]      rd_start,
    output logic [IDX_W-1:0]      rd_end
);

    logic [RUN_CNT_W-1:0] count_reg, count_next;
    logic                 in_run_reg, in_run_next;
    logic [IDX_W-1:0]     cur_start_reg, cur_start_next;
    logic [IDX_W-1:0]     rs_reg [MAX_RUNS];
    logic [IDX_W-1:0]     rs_next [MAX_RUNS];
    logic [IDX_W-1:0]     re_reg [MAX_RUNS];
    logic [IDX_W-1:0]     re_next [MAX_RUNS];
    logic                 run_close;

    always_comb
    begin
        count_next     = count_reg;
        in_run_next    = in_run_reg;
        cur_start_next = cur_start_reg;
        rs_next        = rs_reg;
        re_next        = re_reg;
        run_close      = 1'b0;

        if (ctl.start)
        begin
            count_next  = '0;
            in_run_next = 1'b0;
        end
        else if (ctl.step)
        begin
            if (ctl.dirty && !in_run_reg)
            begin
                in_run_next    = 1'b1;
                cur_start_next = idx;
            end
            else if (!ctl.dirty && in_run_reg)
            begin
                in_run_next = 1'b0;
                run_close   = 1'b1;
            end
        end
        else if (ctl.finish && in_run_reg)
        begin
            in_run_next = 1'b0;
            run_close   = 1'b1;
        end

        // slots full: the last slot stretches to the newest run end
        if (run_close)
        begin
            if (count_reg < RUN_CNT_W'(MAX_RUNS))
            begin
                rs_next[count_reg[RUN_SLOT_W-1:0]] = cur_start_reg;
                re_next[count_reg[RUN_SLOT_W-1:0]] = idx;
                count_next = count_reg + RUN_CNT_W'(1);
            end
            else
            begin
                re_next[MAX_RUNS-1] = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            in_run_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            in_run_reg <= in_run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_start_reg <= cur_start_next;
        rs_reg        <= rs_next;
        re_reg        <= re_next;
    end

    assign run_count = count_reg;
    assign rd_start  = rs_reg[rd_sel];
    assign rd_end    = re_reg[rd_sel];

endmodule

// ===== hw/rtl/dirty_block_writeback_coalescer.sv =====
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | req_t: req_type, head, cylinder
// rsp     | out | rsp_valid/rsp_ready  | rsp_t: storage_addr, run_length, last_run
//
// Write: after acceptance, a read-modify-write sweep of the dirty-map RAM marks
//   every block of the head's range; req_ready stays low until the sweep ends.
// Overflow, unused code, flush with nothing dirty: handled in ST_IDLE, no sweep.
// Flush: a sweep over all CYL_BLOCKS blocks, then ST_CLOSE, then ST_EMIT sends the results.
// After reset a clearing pass over all CYL_BLOCKS blocks runs before req_ready rises.
// A stalled rsp holds the result register; the pass waits only when emitting.
module dirty_block_writeback_coalescer
    import dbwc_pkg::*;
#(
    parameter int unsigned HEAD_COUNT     = HEAD_COUNT_DEF,
    parameter int unsigned TRACK_SIZE     = TRACK_SIZE_DEF,
    parameter int unsigned CYLINDER_COUNT = CYLINDER_COUNT_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Geometry, all settled at elaboration.
    localparam int unsigned CYL_BYTES  = HEAD_COUNT * TRACK_SIZE;
    localparam int unsigned CYL_BLOCKS = (CYL_BYTES + BLK_BYTES - 1) / BLK_BYTES;
    localparam int unsigned TRK_BLOCKS = TRACK_SIZE / BLK_BYTES;
    localparam int unsigned HALF       = TRK_BLOCKS / 2;
    localparam int unsigned BW         = $clog2(CYL_BLOCKS + 1);
    localparam int unsigned AW         = (CYL_BLOCKS > 1) ? $clog2(CYL_BLOCKS) : 1;
    localparam int unsigned HD_W       = (HEAD_COUNT > 1) ? $clog2(HEAD_COUNT) : 1;
    localparam int unsigned PH_W       = $clog2(HEAD_COUNT + 1);
    localparam int unsigned OFF_W      = (TRK_BLOCKS > 1) ? $clog2(TRK_BLOCKS) : 1;
    localparam int unsigned CNT_W      = $clog2(TRK_BLOCKS + 1);
    localparam int unsigned BYTE_W     = BW + BLK_SHIFT;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_SCAN,
        ST_CLOSE,
        ST_EMIT
    } state_t;

    // Per-head tables: first block, end block (exclusive, clipped to the
    // cylinder), and where the first block sits in the promotion grouping.
    // Promotion groups are TRK_BLOCKS wide, so for tracks that are not a
    // whole number of blocks they drift from the write ranges; a group index
    // of HEAD_COUNT means the block belongs to no group.
    logic [BW-1:0]    first_tab [HEAD_COUNT];
    logic [BW-1:0]    end_tab   [HEAD_COUNT];
    logic [PH_W-1:0]  ph_tab    [HEAD_COUNT];
    logic [OFF_W-1:0] off_tab   [HEAD_COUNT];

    for (genvar g = 0; g < HEAD_COUNT; g++)
    begin : g_head
        localparam int unsigned FIRST  = (g * TRACK_SIZE) / BLK_BYTES;
        localparam int unsigned STOP_X = (g * TRACK_SIZE + TRACK_SIZE + BLK_BYTES - 1)
                                         / BLK_BYTES;
        localparam int unsigned STOP   = (STOP_X < CYL_BLOCKS) ? STOP_X : CYL_BLOCKS;
        localparam int unsigned PH0    = FIRST / TRK_BLOCKS;
        localparam int unsigned OFF0   = FIRST % TRK_BLOCKS;

        assign first_tab[g] = BW'(FIRST);
        assign end_tab[g]   = BW'(STOP);
        assign ph_tab[g]    = (PH0 < HEAD_COUNT) ? PH_W'(PH0) : PH_W'(HEAD_COUNT);
        assign off_tab[g]   = (PH0 < HEAD_COUNT) ? OFF_W'(OFF0) : '0;
    end

    state_t              state_reg, state_next;
    logic [BW-1:0]       addr_reg, addr_next;       // sweep read pointer
    logic [BW-1:0]       end_reg, end_next;         // sweep limit for a write
    logic [PH_W-1:0]     ph_reg, ph_next;           // promotion group of addr_reg
    logic [OFF_W-1:0]    off_reg, off_next;         // offset inside that group
    logic                p1_valid_reg, p1_valid_next;
    logic [AW-1:0]       p1_addr_reg, p1_addr_next;
    logic [PH_W-1:0]     p1_ph_reg, p1_ph_next;
    logic [CNT_W-1:0]    cnt_reg [HEAD_COUNT];      // dirty blocks per group
    logic [CNT_W-1:0]    cnt_next [HEAD_COUNT];
    logic                any_dirty_reg, any_dirty_next;
    logic                whole_reg, whole_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [RUN_SLOT_W-1:0] emit_reg, emit_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    // Dirty-map RAM port signals.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic                ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic                ram_rdata;

    scan_ctl_t           run_ctl;
    logic [BW-1:0]       run_idx;
    logic [RUN_CNT_W-1:0] run_count;
    logic [BW-1:0]       run_start;
    logic [BW-1:0]       run_end;

    logic [HD_W-1:0]     hd_sel;
    logic [9:0]          cyl_sel;
    logic [31:0]         base_prod;
    logic [HEAD_COUNT-1:0] promo;
    logic                p1_in;
    logic                p1_promo;
    logic [BW-1:0]       sweep_limit;
    logic                out_free;
    logic                emit_last;
    logic [BYTE_W-1:0]   pos_bytes;
    logic [BYTE_W-1:0]   end_bytes;
    logic [BYTE_W-1:0]   len_bytes;

    dbwc_ram #(
        .WIDTH (1),
        .DEPTH (CYL_BLOCKS)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    dbwc_runs #(
        .IDX_W (BW)
    ) u_runs (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (run_ctl),
        .idx       (run_idx),
        .rd_sel    (emit_reg),
        .run_count (run_count),
        .rd_start  (run_start),
        .rd_end    (run_end)
    );

    // Request decode: clamp head and cylinder, cylinder base address.
    assign hd_sel    = (32'(req.head) >= HEAD_COUNT) ? HD_W'(HEAD_COUNT - 1)
                                                     : HD_W'(req.head);
    assign cyl_sel   = (32'(req.cylinder) >= CYLINDER_COUNT) ? 10'(CYLINDER_COUNT - 1)
                                                             : req.cylinder;
    assign base_prod = 32'(cyl_sel) * 32'(CYL_BYTES);

    // A group at least half dirty gets written back whole.
    for (genvar h = 0; h < HEAD_COUNT; h++)
    begin : g_promo
        assign promo[h] = (cnt_reg[h] >= CNT_W'(HALF));
    end

    assign p1_in       = (p1_ph_reg != PH_W'(HEAD_COUNT));
    assign p1_promo    = p1_in && promo[p1_ph_reg[HD_W-1:0]];
    assign sweep_limit = (state_reg == ST_MARK) ? end_reg : BW'(CYL_BLOCKS);
    assign run_idx     = run_ctl.finish ? BW'(CYL_BLOCKS) : BW'(p1_addr_reg);
    assign out_free    = !rsp_valid_reg || rsp_ready;

    // Result math: byte start, byte end, length clipped at the cylinder end.
    assign pos_bytes = BYTE_W'(run_start) << BLK_SHIFT;
    assign end_bytes = BYTE_W'(run_end) << BLK_SHIFT;
    assign len_bytes = (end_bytes > BYTE_W'(CYL_BYTES)) ? BYTE_W'(CYL_BYTES) - pos_bytes
                                                        : end_bytes - pos_bytes;
    assign emit_last = whole_reg ||
                       (RUN_CNT_W'(emit_reg) + RUN_CNT_W'(1) == run_count);

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        end_next       = end_reg;
        ph_next        = ph_reg;
        off_next       = off_reg;
        p1_valid_next  = 1'b0;
        p1_addr_next   = p1_addr_reg;
        p1_ph_next     = p1_ph_reg;
        cnt_next       = cnt_reg;
        any_dirty_next = any_dirty_reg;
        whole_next     = whole_reg;
        base_next      = base_reg;
        emit_next      = emit_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        ram_we    = 1'b0;
        ram_waddr = p1_addr_reg;
        ram_wdata = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = addr_reg[AW-1:0];
        run_ctl   = '0;

        // Second half of the sweep: read data is back, write the block.
        // Addresses rise through a sweep, so the write never meets the read.
        if (p1_valid_reg)
        begin
            ram_we = 1'b1;
            if (state_reg == ST_MARK)
            begin
                ram_wdata = 1'b1;
                if (!ram_rdata && p1_in)
                begin
                    cnt_next[p1_ph_reg[HD_W-1:0]] = cnt_reg[p1_ph_reg[HD_W-1:0]]
                                                    + CNT_W'(1);
                end
            end
            else
            begin
                // flush clears behind itself; promotion is off for whole cylinder
                ram_wdata     = 1'b0;
                run_ctl.step  = !whole_reg;
                run_ctl.dirty = ram_rdata || p1_promo;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg[AW-1:0];
                ram_wdata = 1'b0;
                addr_next = addr_reg + BW'(1);
                if (addr_reg == BW'(CYL_BLOCKS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.req_type)
                        REQ_WRITE:
                        begin
                            addr_next      = first_tab[hd_sel];
                            end_next       = end_tab[hd_sel];
                            ph_next        = ph_tab[hd_sel];
                            off_next       = off_tab[hd_sel];
                            any_dirty_next = 1'b1;
                            state_next     = ST_MARK;
                        end
                        REQ_OVERFLOW:
                        begin
                            whole_next = 1'b1;
                        end
                        REQ_FLUSH:
                        begin
                            if (any_dirty_reg)
                            begin
                                base_next     = base_prod[ADDR_W-1:0];
                                addr_next     = '0;
                                ph_next       = '0;
                                off_next      = '0;
                                run_ctl.start = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_MARK, ST_SCAN:
            begin
                if (addr_reg != sweep_limit)
                begin
                    ram_re        = 1'b1;
                    p1_valid_next = 1'b1;
                    p1_addr_next  = addr_reg[AW-1:0];
                    p1_ph_next    = ph_reg;
                    addr_next     = addr_reg + BW'(1);
                    if (ph_reg != PH_W'(HEAD_COUNT))
                    begin
                        if (off_reg == OFF_W'(TRK_BLOCKS - 1))
                        begin
                            off_next = '0;
                            ph_next  = ph_reg + PH_W'(1);
                        end
                        else
                        begin
                            off_next = off_reg + OFF_W'(1);
                        end
                    end
                end
                else
                begin
                    state_next = (state_reg == ST_MARK) ? ST_IDLE : ST_CLOSE;
                end
            end

            ST_CLOSE:
            begin
                run_ctl.finish = 1'b1;
                any_dirty_next = 1'b0;
                for (int h = 0; h < HEAD_COUNT; h++)
                begin
                    cnt_next[h] = '0;
                end
                emit_next  = '0;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (whole_reg)
                    begin
                        rsp_next.storage_addr = base_reg;
                        rsp_next.run_length   = LEN_W'(CYL_BYTES);
                    end
                    else
                    begin
                        rsp_next.storage_addr = base_reg + ADDR_W'(pos_bytes);
                        rsp_next.run_length   = LEN_W'(len_bytes);
                    end
                    rsp_next.last_run = emit_last;
                    emit_next         = emit_reg + RUN_SLOT_W'(1);
                    if (emit_last)
                    begin
                        whole_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            end_reg       <= '0;
            ph_reg        <= '0;
            off_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p1_addr_reg   <= '0;
            p1_ph_reg     <= '0;
            for (int h = 0; h < HEAD_COUNT; h++)
            begin
                cnt_reg[h] <= '0;
            end
            any_dirty_reg <= 1'b0;
            whole_reg     <= 1'b0;
            base_reg      <= '0;
            emit_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            end_reg       <= end_next;
            ph_reg        <= ph_next;
            off_reg       <= off_next;
            p1_valid_reg  <= p1_valid_next;
            p1_addr_reg   <= p1_addr_next;
            p1_ph_reg     <= p1_ph_next;
            cnt_reg       <= cnt_next;
            any_dirty_reg <= any_dirty_next;
            whole_reg     <= whole_next;
            base_reg      <= base_next;
            emit_reg      <= emit_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/dbwc_checker.sv =====
`include "dirty_block_writeback_coalescer_defines.svh"

module dbwc_checker
    import dbwc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // stalled result holds
    `DBWC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // a write always sweeps at least one block
    `DBWC_ASSERT_NEXT(a_write_busy, req_valid && req_ready && req.req_type == REQ_WRITE,
                      !req_ready)

    // results come only from a flush in progress
    `DBWC_ASSERT_SAME(a_rsp_from_flush, $rose(rsp_valid), !$past(req_ready))

    // non-flush items never start a result
    `DBWC_ASSERT_NEXT(a_event_quiet, req_valid && req_ready && req.req_type != REQ_FLUSH,
                      !$rose(rsp_valid))

endmodule

bind dirty_block_writeback_coalescer dbwc_checker u_dbwc_checker (.*);
